/* hw/rtl/ilist_pkg.sv */
// package for the indexed list block: sizes, function and status codes, state type
// no dependencies
package ilist_pkg;

	localparam int DEPTH    = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 5;
	localparam int VAL_W    = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W + 1 : IDX_W + 1;

	// function codes
	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DROP   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RDWAIT,
		S_SHIFT,
		S_FINAL,
		S_RESP
	} state_t;

endpackage

/* hw/rtl/indexed_list_insert_erase.sv */
// indexed list of signed words with append, drop, insert, erase, read and clear
// each word goes from idle to decide, then to a read wait for read, or to a shift loop over the ram for
// insert and erase that moves one entry per step (up to DEPTH-1 entries) plus a final write for insert
// before the response; the block takes no new word until its result has moved into the output register
// reset: count and control clear at once, list contents stay undefined until written
// depends on ilist_pkg and ilist_ram
module indexed_list_insert_erase
	import ilist_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// input words
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [FUNC_W-1:0]          func,
	input  logic [IDX_W-1:0]           index,
	input  logic signed [VAL_W-1:0]    value,
	// result words
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [VAL_W-1:0]    read_value,
	output logic [COUNT_W-1:0]         count,
	output logic [STATUS_W-1:0]        status
);

	// fsm
	state_t state_q, state_d;

	// latched input word
	logic [FUNC_W-1:0]   func_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VAL_W-1:0]    val_q;

	// list length and shift pointer
	logic [CNT_W-1:0]    count_q, count_d;
	logic [ADDR_W-1:0]   ptr_q, ptr_d;

	// pending result, held until the output register is free
	logic [VAL_W-1:0]    rd_q, rd_d;
	logic [STATUS_W-1:0] st_q, st_d;

	// output register
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_val_q;
	logic [COUNT_W-1:0]  out_cnt_q;
	logic [STATUS_W-1:0] out_st_q;

	// ram interface
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [VAL_W-1:0]    mem_wdata, mem_rdata;

	logic in_accept, out_load;

	// decode of the latched word against the current length
	logic [CMP_W-1:0]  idx_ext, cnt_ext;
	logic              full, empty, idx_gt, idx_ge;
	logic              ins_ok, ins_shift, ers_ok, ers_shift;
	logic [ADDR_W-1:0] idx_addr, cnt_addr, last_addr;

	assign idx_ext   = CMP_W'(idx_q);
	assign cnt_ext   = CMP_W'(count_q);
	assign full      = (cnt_ext >= CMP_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign idx_gt    = (idx_ext > cnt_ext);
	assign idx_ge    = (idx_ext >= cnt_ext);
	// insert at the end needs no shift, likewise erase of the last entry
	assign ins_ok    = !idx_gt && !full;
	assign ins_shift = ins_ok && (idx_ext != cnt_ext);
	assign ers_ok    = !idx_ge;
	assign ers_shift = ers_ok && ((idx_ext + CMP_W'(1)) != cnt_ext);
	assign idx_addr  = ADDR_W'(idx_q);
	assign cnt_addr  = ADDR_W'(count_q);
	assign last_addr = ADDR_W'(count_q - CNT_W'(1));

	assign in_accept = in_valid && !in_stall;
	// result moves out once the output register is empty or being drained
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	ilist_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (func_q)
					FN_READ:   state_d = ers_ok ? S_RDWAIT : S_RESP;
					FN_INSERT: state_d = ins_shift ? S_SHIFT : S_RESP;
					FN_ERASE:  state_d = ers_shift ? S_SHIFT : S_RESP;
					default:   state_d = S_RESP;
				endcase
			end
			S_RDWAIT: state_d = S_RESP;
			S_SHIFT: begin
				if (func_q == FN_INSERT) begin
					if (ptr_q == idx_addr) begin
						state_d = S_FINAL;
					end
				end else if (ptr_q == last_addr) begin
					state_d = S_RESP;
				end
			end
			S_FINAL: state_d = S_RESP;
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the fsm: ram control and datapath updates
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_raddr = '0;
		count_d   = count_q;
		ptr_d     = ptr_q;
		rd_d      = rd_q;
		st_d      = st_q;
		case (state_q)
			S_DECIDE: begin
				rd_d = '0;
				st_d = ST_OK;
				case (func_q)
					FN_APPEND: begin
						if (full) begin
							st_d = ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = cnt_addr;
							count_d   = count_q + CNT_W'(1);
						end
					end
					FN_DROP: begin
						if (empty) begin
							st_d = ST_EMPTY;
						end else begin
							count_d = count_q - CNT_W'(1);
						end
					end
					FN_INSERT: begin
						if (idx_gt) begin
							st_d = ST_RANGE;
						end else if (full) begin
							st_d = ST_FULL;
						end else if (ins_shift) begin
							// walk down from the last entry
							mem_raddr = last_addr;
							ptr_d     = last_addr;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = idx_addr;
							count_d   = count_q + CNT_W'(1);
						end
					end
					FN_ERASE: begin
						if (!ers_ok) begin
							st_d = ST_RANGE;
						end else if (ers_shift) begin
							// walk up from the entry after the hole
							mem_raddr = idx_addr + ADDR_W'(1);
							ptr_d     = idx_addr + ADDR_W'(1);
						end else begin
							count_d = count_q - CNT_W'(1);
						end
					end
					FN_READ: begin
						if (!ers_ok) begin
							st_d = ST_RANGE;
						end else begin
							mem_raddr = idx_addr;
						end
					end
					FN_CLEAR: count_d = '0;
					default: ;
				endcase
			end
			S_RDWAIT: rd_d = mem_rdata;
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				if (func_q == FN_INSERT) begin
					// data read last cycle moves one place up
					mem_waddr = ptr_q + ADDR_W'(1);
					mem_raddr = ptr_q - ADDR_W'(1);
					ptr_d     = ptr_q - ADDR_W'(1);
				end else begin
					// data read last cycle moves one place down
					mem_waddr = ptr_q - ADDR_W'(1);
					mem_raddr = ptr_q + ADDR_W'(1);
					ptr_d     = ptr_q + ADDR_W'(1);
					if (ptr_q == last_addr) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			S_FINAL: begin
				mem_we    = 1'b1;
				mem_waddr = idx_addr;
				count_d   = count_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func;
			idx_q  <= index;
			val_q  <= value;
		end
		ptr_q <= ptr_d;
		rd_q  <= rd_d;
		st_q  <= st_d;
		if (out_load) begin
			out_val_q <= rd_q;
			out_cnt_q <= COUNT_W'(count_q);
			out_st_q  <= st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_val_q;
	assign count      = out_cnt_q;
	assign status     = out_st_q;

endmodule

/* hw/rtl/ilist_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
module ilist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/ilist_chk.sv */
// port-level checker for the indexed list block, bound to the top level
// depends on ilist_pkg
module ilist_chk
	import ilist_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] read_value,
	input logic [COUNT_W-1:0]      count,
	input logic [STATUS_W-1:0]     status
);

	// one word in flight: input side closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// length never goes past capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(count) <= DEPTH))
		else $error("count beyond capacity");

	// read data only with a good status
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (read_value == '0))
		else $error("read data on failed word");

	// full flag only when the list is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (32'(count) == DEPTH))
		else $error("full status below capacity");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_value)
			&& $stable(count) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind indexed_list_insert_erase ilist_chk u_ilist_chk (.*);

/* tb/sv/tb_indexed_list_insert_erase.sv */
// self-checking testbench for indexed_list_insert_erase: directed and random list operations
// with a per-word predictor, random idling on both channels and long output holds
// depends on ilist_pkg and the indexed_list_insert_erase rtl
module tb_indexed_list_insert_erase;
	import ilist_pkg::*;

	// the two func codes the block treats as no-ops
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	// cycles with no handshake on either side before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// quiet cycles let pass after the last result, well above the longest shift
	localparam int TAIL_CYCLES = 3 * DEPTH + 8;

	typedef struct packed {
		logic [VAL_W-1:0]    rd;
		logic [COUNT_W-1:0]  cnt;
		logic [STATUS_W-1:0] st;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [FUNC_W-1:0]       func = '0;
	logic [IDX_W-1:0]        index = '0;
	logic signed [VAL_W-1:0] value = '0;

	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [COUNT_W-1:0]      count;
	logic [STATUS_W-1:0]     status;

	// predictor copy of the list
	logic signed [VAL_W-1:0] list_words [DEPTH];
	int                      list_len = 0;

	// one expected result per accepted word, oldest first
	list_result_t expected_list_results [$];

	// idling mix in percent per cycle, changed between phases
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold: asked for by a test, counted down in the receiver process
	int hold_ask = 0;
	int hold_left = 0;

	// random stimulus trend, flips now and then so the list swings between empty and full
	bit growing = 1'b1;

	int mismatches = 0;
	int words_sent = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int times_full = 0;
	int times_emptied = 0;
	int quiet_cycles = 0;

	indexed_list_insert_erase u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.count      (count),
		.status     (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one line per mismatch
	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		mismatches++;
	endtask

	// predictor: applies one list operation to the local copy and returns its result
	function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
			input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] v);
		list_result_t r;
		int pos;
		int k;
		int prev_len;
		pos = int'(idx);
		prev_len = list_len;
		r.rd = '0;
		r.st = ST_OK;
		case (f)
			FN_APPEND: begin
				if (list_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					list_words[list_len] = v;
					list_len++;
				end
			end
			FN_DROP: begin
				if (list_len == 0) begin
					r.st = ST_EMPTY;
				end else begin
					list_len--;
				end
			end
			FN_INSERT: begin
				// range is checked before fullness
				if (pos > list_len) begin
					r.st = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					for (k = list_len; k > pos; k--) begin
						list_words[k] = list_words[k-1];
					end
					list_words[pos] = v;
					list_len++;
				end
			end
			FN_ERASE: begin
				if (pos >= list_len) begin
					r.st = ST_RANGE;
				end else begin
					for (k = pos; k + 1 < list_len; k++) begin
						list_words[k] = list_words[k+1];
					end
					list_len--;
				end
			end
			FN_READ: begin
				if (pos >= list_len) begin
					r.st = ST_RANGE;
				end else begin
					r.rd = list_words[pos];
				end
			end
			FN_CLEAR: begin
				// stored words stay in place, only the length drops
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.cnt = COUNT_W'(list_len);
		status_seen[r.st]++;
		if (list_len == DEPTH && prev_len != DEPTH) begin
			times_full++;
		end
		if (list_len == 0 && prev_len != 0) begin
			times_emptied++;
		end
		return r;
	endfunction

	// offers one word, idling first at the current mix, and books its expected result
	// once accepted; valid stays high afterward so back-to-back words need no extra edge
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		index <= idx;
		value <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		expected_list_results = {expected_list_results, apply_list_op(f, idx, v)};
		words_sent++;
	endtask

	// sender goes quiet until every booked result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_list_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// random word shaped by the current list length: mostly legal positions, some noise
	task automatic send_random_words(input int n);
		logic [FUNC_W-1:0]       f;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] v;
		int roll;
		repeat (n) begin
			if ($urandom_range(49) == 0) begin
				growing = !growing;
			end
			roll = $urandom_range(99);
			if (roll < 3) begin
				// any code, spare ones included
				f = FUNC_W'($urandom_range(7));
			end else if (roll < 5) begin
				f = FN_CLEAR;
			end else if (roll < 25) begin
				f = FN_READ;
			end else if (($urandom_range(99) < 75) == growing) begin
				f = $urandom_range(1) ? FN_APPEND : FN_INSERT;
			end else begin
				f = $urandom_range(1) ? FN_DROP : FN_ERASE;
			end

			roll = $urandom_range(99);
			if (roll < 10) begin
				idx = IDX_W'($urandom_range(31));
			end else if (f == FN_INSERT) begin
				idx = (roll < 25) ? IDX_W'(list_len) : IDX_W'($urandom_range(list_len));
			end else begin
				idx = (list_len == 0) ? '0 :
					(roll < 25) ? IDX_W'(list_len - 1) :
					IDX_W'($urandom_range(list_len - 1));
			end

			case ($urandom_range(15))
				0: v = VAL_MIN;
				1: v = VAL_MAX;
				2: v = '1;
				3: v = '0;
				default: v = $urandom;
			endcase
			send_word(f, idx, v);
		end
	endtask

	// errors on an empty list
	task automatic test_empty_list();
		send_word(FN_DROP, '0, '0);
		send_word(FN_ERASE, '0, '0);
		send_word(FN_READ, '0, '0);
		send_word(FN_INSERT, 5'd1, 32'h1234_5678);
	endtask

	// unused codes change nothing
	task automatic test_spare_codes();
		send_word(FN_SPARE_LO, 5'h1f, '1);
		send_word(FN_SPARE_HI, 5'h0a, VAL_MIN);
	endtask

	// fill with extremes at both ends, then inserts at the head for full-length shifts
	task automatic test_fill_to_capacity();
		send_word(FN_APPEND, '0, VAL_MAX);
		send_word(FN_APPEND, '0, VAL_MIN);
		send_word(FN_INSERT, '0, '1);
		send_word(FN_INSERT, 5'd3, '0);
		while (list_len < DEPTH) begin
			send_word(FN_INSERT, '0, $urandom);
		end
	endtask

	// full list: overflow, range checked before fullness, bounds at count
	task automatic test_full_list();
		send_word(FN_APPEND, '0, 32'h0bad_f00d);
		send_word(FN_INSERT, IDX_W'(DEPTH), 32'h0bad_f00d);
		send_word(FN_INSERT, IDX_W'(DEPTH + 1), 32'h0bad_f00d);
		send_word(FN_READ, IDX_W'(DEPTH - 1), '0);
		send_word(FN_READ, IDX_W'(DEPTH), '0);
		send_word(FN_ERASE, IDX_W'(DEPTH), '0);
	endtask

	// erase at the head shifts everything down, erase at the tail shifts nothing
	task automatic test_erase_and_clear();
		send_word(FN_ERASE, '0, '0);
		send_word(FN_ERASE, IDX_W'(list_len - 1), '0);
		send_word(FN_CLEAR, 5'h1f, '1);
	endtask

	// random traffic under four idling mixes
	task automatic test_random_phases();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		send_random_words(200);
		sender_idle_pct = 79;
		recv_stall_pct = 0;
		send_random_words(160);
		sender_idle_pct = 0;
		recv_stall_pct = 79;
		send_random_words(160);
		sender_idle_pct = 17;
		recv_stall_pct = 17;
		send_random_words(160);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering words
	task automatic test_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_ask = 120;
		send_random_words(25);
	endtask

	// sender pauses mid-stream until the block has answered everything
	task automatic test_drain_pause();
		sender_idle_pct = 17;
		recv_stall_pct = 17;
		send_random_words(10);
		wait_results_drained();
		send_random_words(10);
	endtask

	// receiver: random stall at the current mix, or a long hold when one is asked
	always @(posedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_list_results.size() == 0) begin
				report_mismatch($sformatf(
					"result with nothing expected: read_value %0d count %0d status %0d",
					read_value, count, status));
			end else begin
				want = expected_list_results.pop_front();
				results_checked++;
				if (read_value !== want.rd) begin
					report_mismatch($sformatf("read_value %0d, expected %0d",
						read_value, $signed(want.rd)));
				end
				if (count !== want.cnt) begin
					report_mismatch($sformatf("count %0d, expected %0d", count, want.cnt));
				end
				if (status !== want.st) begin
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				end
			end
		end
	end

	// watchdog: a long stretch with no handshake on either side means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_list_results.size());
			$display("** indexed_list_insert_erase: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_spare_codes();
		test_fill_to_capacity();
		test_full_list();
		test_erase_and_clear();
		test_random_phases();
		test_backpressure();
		test_drain_pause();

		// all stimulus in: wait out the answers, then a quiet tail for stray results
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d words in, %0d results checked", words_sent, results_checked);
		$display("ok %0d, full %0d, range %0d, empty %0d; filled %0d times, emptied %0d times",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
			status_seen[ST_EMPTY], times_full, times_emptied);
		if (mismatches == 0) begin
			$display("** indexed_list_insert_erase: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** indexed_list_insert_erase: FAILED **");
		end
		$finish;
	end

endmodule
